FILE: hw/rtl/hal_pkg.sv
// Shared types and constants of the hierarchical address loop table.
package hal_pkg;

  localparam int ModeWidth  = 2;
  localparam int IdsWidth   = 64;
  localparam int LenWidth   = 4;
  localparam int CountWidth = 6;
  localparam int LimitWidth = 6;
  localparam int IdBits     = 8;
  localparam int MaxIds     = IdsWidth / IdBits;
  localparam int QueueDepth = 2;
  localparam logic [LimitWidth-1:0] LimitReset = LimitWidth'(32);

  typedef enum logic [ModeWidth-1:0] {
    MODE_ADD   = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef struct packed {
    logic                known;
    mode_e               op;
    logic [IdsWidth-1:0] ids;
    logic [LenWidth-1:0] len;
  } cmd_t;

endpackage

FILE: hw/rtl/hal_if.sv
// Handshake interfaces for the input and result channels.
interface hal_in_if;
  logic                          valid;
  logic                          ready;
  logic [hal_pkg::ModeWidth-1:0] mode;
  logic [hal_pkg::IdsWidth-1:0]  address_ids;
  logic [hal_pkg::LenWidth-1:0]  address_len;

  modport source (output valid, mode, address_ids, address_len, input ready);
  modport sink (input valid, mode, address_ids, address_len, output ready);
endinterface

interface hal_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic                           loop_found;
  logic [hal_pkg::LenWidth-1:0]   prefix_len;
  logic [hal_pkg::CountWidth-1:0] entry_count;

  modport source (output valid, accepted, loop_found, prefix_len, entry_count, input ready);
  modport sink (input valid, accepted, loop_found, prefix_len, entry_count, output ready);
endinterface

FILE: hw/rtl/hal_front.sv
// Front end: accepts items, classifies the mode and normalizes the address.
module hal_front #(
  parameter int MAX_LEVELS = 8
) (
  hal_in_if.sink          in_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output hal_pkg::cmd_t   q_cmd_o
);

  localparam logic [hal_pkg::LenWidth-1:0] MaxLen = hal_pkg::LenWidth'(MAX_LEVELS);

  logic [hal_pkg::LenWidth-1:0] len_sat;
  logic [hal_pkg::IdsWidth-1:0] ids_masked;

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;

  always_comb begin
    len_sat = (in_i.address_len > MaxLen) ? MaxLen : in_i.address_len;
    for (int j = 0; j < hal_pkg::MaxIds; j++) begin
      ids_masked[j*hal_pkg::IdBits +: hal_pkg::IdBits] =
        (hal_pkg::LenWidth'(j) < len_sat) ?
        in_i.address_ids[j*hal_pkg::IdBits +: hal_pkg::IdBits] : '0;
    end
  end

  always_comb begin
    q_cmd_o.ids = ids_masked;
    q_cmd_o.len = len_sat;
    unique case (in_i.mode)
      hal_pkg::MODE_ADD: begin
        q_cmd_o.known = 1'b1;
        q_cmd_o.op    = hal_pkg::MODE_ADD;
      end
      hal_pkg::MODE_CHECK: begin
        q_cmd_o.known = 1'b1;
        q_cmd_o.op    = hal_pkg::MODE_CHECK;
      end
      hal_pkg::MODE_CLEAR: begin
        q_cmd_o.known = 1'b1;
        q_cmd_o.op    = hal_pkg::MODE_CLEAR;
      end
      default: begin
        q_cmd_o.known = 1'b0;
        q_cmd_o.op    = hal_pkg::MODE_CLEAR;
      end
    endcase
  end

endmodule

FILE: hw/rtl/hal_queue.sv
// Short command queue between the front end and the table engine.
module hal_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hal_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hal_pkg::cmd_t cmd_o
);

  localparam int PtrW = (hal_pkg::QueueDepth > 1) ? $clog2(hal_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(hal_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(hal_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(hal_pkg::QueueDepth);

  hal_pkg::cmd_t   slot_q [hal_pkg::QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/hal_back.sv
// Table engine: stores addresses, scans the table for loops and registers results.
module hal_back #(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_LEVELS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hal_pkg::LimitWidth-1:0] cfg_wdata_i,
  input  logic                           q_valid_i,
  input  hal_pkg::cmd_t                  q_cmd_i,
  output logic                           q_pop_o,
  hal_out_if.source                      out_o
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int IdsW = MAX_LEVELS * hal_pkg::IdBits;
  localparam int LenW = hal_pkg::LenWidth;
  localparam int EntW = IdsW + LenW;
  localparam int LimW = (CntW > hal_pkg::LimitWidth) ? CntW : hal_pkg::LimitWidth;
  localparam logic [LimW-1:0] DepthLim = LimW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e                         state_q, state_d;
  logic [hal_pkg::LimitWidth-1:0] limit_q;
  logic [CntW-1:0]                count_q, count_d;
  logic [CntW-1:0]                idx_q, idx_d;
  logic                           rd_vld_q, rd_vld_d;
  logic [IdsW-1:0]                key_q, key_d;
  logic [LenW-1:0]                klen_q, klen_d;
  logic [LenW-1:0]                best_q, best_d;
  logic                           out_vld_q, out_vld_d;
  logic                           acc_q, acc_d;
  logic                           found_q, found_d;
  logic [LenW-1:0]                plen_q, plen_d;
  logic [hal_pkg::CountWidth-1:0] ecnt_q, ecnt_d;

  logic [EntW-1:0] mem_q [TABLE_DEPTH];
  logic [EntW-1:0] rd_q;
  logic            mem_we, rd_en;
  logic [LimW-1:0] lim_ext, lim_eff;
  logic            can_add, out_free, hit;
  logic [LenW-1:0] rd_len;
  logic [IdsW-1:0] rd_ids, cmp_mask;

  assign lim_ext  = LimW'(limit_q);
  assign lim_eff  = (lim_ext > DepthLim) ? DepthLim : lim_ext;
  assign can_add  = (LimW'(count_q) < lim_eff);
  assign out_free = !out_vld_q || out_o.ready;
  assign rd_len   = rd_q[EntW-1 -: LenW];
  assign rd_ids   = rd_q[IdsW-1:0];

  always_comb begin
    for (int j = 0; j < MAX_LEVELS; j++) begin
      cmp_mask[j*hal_pkg::IdBits +: hal_pkg::IdBits] =
        {hal_pkg::IdBits{LenW'(j) < rd_len}};
    end
  end

  assign hit = rd_vld_q && (rd_len != '0) && (rd_len < klen_q) && (rd_len > best_q) &&
               (((rd_ids ^ key_q) & cmp_mask) == '0);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[AddrW-1:0]] <= {q_cmd_i.len, q_cmd_i.ids[IdsW-1:0]};
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[AddrW-1:0]];
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    key_d     = key_q;
    klen_d    = klen_q;
    best_d    = best_q;
    out_vld_d = out_vld_q && !out_o.ready;
    acc_d     = acc_q;
    found_d   = found_q;
    plen_d    = plen_q;
    ecnt_d    = ecnt_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.known && q_cmd_i.op == hal_pkg::MODE_CHECK) begin
            q_pop_o = 1'b1;
            key_d   = q_cmd_i.ids[IdsW-1:0];
            klen_d  = q_cmd_i.len;
            best_d  = '0;
            idx_d   = '0;
            state_d = ST_SCAN;
          end else if (out_free) begin
            q_pop_o   = 1'b1;
            out_vld_d = 1'b1;
            acc_d     = 1'b0;
            found_d   = 1'b0;
            plen_d    = '0;
            if (q_cmd_i.known && q_cmd_i.op == hal_pkg::MODE_ADD && can_add) begin
              mem_we  = 1'b1;
              acc_d   = 1'b1;
              count_d = CntW'(count_q + 1'b1);
            end else if (q_cmd_i.known && q_cmd_i.op == hal_pkg::MODE_CLEAR) begin
              count_d = '0;
            end
            ecnt_d = hal_pkg::CountWidth'(count_d);
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          best_d = rd_len;
        end
        if (idx_q < count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          idx_d    = CntW'(idx_q + 1'b1);
        end else if (!rd_vld_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          acc_d     = 1'b0;
          found_d   = (best_q != '0);
          plen_d    = best_q;
          ecnt_d    = hal_pkg::CountWidth'(count_q);
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      limit_q   <= hal_pkg::LimitReset;
      count_q   <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      best_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      best_q    <= best_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_d_unused_guard: begin
      key_q  <= key_d;
      klen_q <= klen_d;
      acc_q  <= acc_d;
      found_q <= found_d;
      plen_q <= plen_d;
      ecnt_q <= ecnt_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.accepted    = acc_q;
  assign out_o.loop_found  = found_q;
  assign out_o.prefix_len  = plen_q;
  assign out_o.entry_count = ecnt_q;

endmodule

FILE: hw/rtl/hierarchical_address_loop_table.sv
// Top level of the hierarchical address loop table.
// An add, clear or unknown item is handled in the idle state of the table
// engine once the result register is free. A check reads every stored entry
// once through the single read port of the table memory. A two-entry queue
// lets the input side take items while the engine scans, and a registered
// result lets the engine start the next check while a result waits. Entries
// are written only at the fill position and only entries below the count are
// read, so the table needs no clearing after reset.
module hierarchical_address_loop_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_LEVELS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hal_pkg::LimitWidth-1:0] cfg_wdata_i,
  hal_in_if.sink                         in_i,
  hal_out_if.source                      out_o
);

  logic          q_push, q_full, q_pop, q_valid;
  hal_pkg::cmd_t q_wcmd, q_rcmd;

  hal_front #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_front (
    .in_i    (in_i),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_cmd_o (q_wcmd)
  );

  hal_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_wcmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_rcmd)
  );

  hal_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_rcmd),
    .q_pop_o    (q_pop),
    .out_o      (out_o)
  );

endmodule
